// File: design/p1ts_pkg.sv
// ----------------------------------------------------------------------------
// p1ts_pkg
// Shared constants, lane map and side-band type for the P1 triangle
// stiffness pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package p1ts_pkg;

    // Default port widths
    localparam int P1TS_COORD_WIDTH = 32;
    localparam int P1TS_ENTRY_WIDTH = 40;

    // Q16.16 coordinates: numerator is scaled by 2 * 2^15 before the divide
    localparam int NUM_SHIFT = 16;

    // The matrix is symmetric: six distinct entries, one divider lane each
    localparam int NUM_LANES = 6;
    localparam int LANE_00   = 0;
    localparam int LANE_01   = 1;
    localparam int LANE_02   = 2;
    localparam int LANE_11   = 3;
    localparam int LANE_12   = 4;
    localparam int LANE_22   = 5;

    localparam int LANE_ROW [NUM_LANES] = '{0, 0, 0, 1, 1, 2};
    localparam int LANE_COL [NUM_LANES] = '{0, 1, 2, 1, 2, 2};

    // Flags that ride alongside the divider data
    typedef struct packed {
        logic                 bad;
        logic [NUM_LANES-1:0] neg;
    } p1ts_side_t;

    // Width of the rounded dividend |N| * 2^16 + det
    function automatic int num_width(input int coord_width);
        return 2 * coord_width + NUM_SHIFT + 2;
    endfunction

    // Width of the divisor 2 * det
    function automatic int den_width(input int coord_width);
        return 2 * coord_width + 2;
    endfunction

endpackage

`default_nettype wire

// File: design/p1ts_front.sv
// ----------------------------------------------------------------------------
// p1ts_front
// Five-stage front end: edge terms, products, determinant and numerators,
// magnitudes and signs, then the rounded dividend and the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module p1ts_front
    import p1ts_pkg::*;
#(
    parameter int  COORD_WIDTH = P1TS_COORD_WIDTH,
    localparam int NUM_W       = num_width(COORD_WIDTH),
    localparam int DEN_W       = den_width(COORD_WIDTH)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] node0_x,
    input  logic signed [COORD_WIDTH-1:0] node0_y,
    input  logic signed [COORD_WIDTH-1:0] node1_x,
    input  logic signed [COORD_WIDTH-1:0] node1_y,
    input  logic signed [COORD_WIDTH-1:0] node2_x,
    input  logic signed [COORD_WIDTH-1:0] node2_y,
    output logic                          out_valid,
    output logic        [NUM_W-1:0]       num [NUM_LANES],
    output logic        [DEN_W-1:0]       den,
    output p1ts_side_t                    side
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * COORD_WIDTH + 2;
    localparam int MAG_W  = 2 * COORD_WIDTH + 1;
    localparam int STAGES = 5;

    logic [STAGES-1:0] valid_reg;

    logic signed [DIFF_W-1:0] b_reg [3];
    logic signed [DIFF_W-1:0] c_reg [3];

    logic signed [PROD_W-1:0] detp_reg;
    logic signed [PROD_W-1:0] detq_reg;
    logic signed [PROD_W-1:0] bb_reg [NUM_LANES];
    logic signed [PROD_W-1:0] cc_reg [NUM_LANES];

    logic signed [PROD_W-1:0] det3_reg;
    logic signed [PROD_W-1:0] n3_reg [NUM_LANES];

    logic                     bad4_reg;
    logic [NUM_LANES-1:0]     neg4_reg;
    logic [MAG_W-1:0]         det4_reg;
    logic [MAG_W-1:0]         mag4_reg [NUM_LANES];

    p1ts_side_t               side5_reg;
    logic [DEN_W-1:0]         den5_reg;
    logic [NUM_W-1:0]         num5_reg [NUM_LANES];

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Stage 1: edge terms b_i and c_i
    always_ff @(posedge clk)
    begin
        b_reg[0] <= DIFF_W'(node1_y) - DIFF_W'(node2_y);
        b_reg[1] <= DIFF_W'(node2_y) - DIFF_W'(node0_y);
        b_reg[2] <= DIFF_W'(node0_y) - DIFF_W'(node1_y);
        c_reg[0] <= DIFF_W'(node2_x) - DIFF_W'(node1_x);
        c_reg[1] <= DIFF_W'(node0_x) - DIFF_W'(node2_x);
        c_reg[2] <= DIFF_W'(node1_x) - DIFF_W'(node0_x);
    end

    // Stage 2: products; det = c2*b1 - c1*b2
    always_ff @(posedge clk)
    begin
        detp_reg <= c_reg[2] * b_reg[1];
        detq_reg <= c_reg[1] * b_reg[2];
        for (int l = 0; l < NUM_LANES; l++)
        begin
            bb_reg[l] <= b_reg[LANE_ROW[l]] * b_reg[LANE_COL[l]];
            cc_reg[l] <= c_reg[LANE_ROW[l]] * c_reg[LANE_COL[l]];
        end
    end

    // Stage 3: determinant and entry numerators
    always_ff @(posedge clk)
    begin
        det3_reg <= detp_reg - detq_reg;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            n3_reg[l] <= bb_reg[l] + cc_reg[l];
        end
    end

    // Stage 4: flag bad area, split numerators into sign and magnitude
    always_ff @(posedge clk)
    begin
        bad4_reg <= det3_reg[PROD_W-1] || (det3_reg == '0);
        det4_reg <= det3_reg[MAG_W-1:0];
        for (int l = 0; l < NUM_LANES; l++)
        begin
            neg4_reg[l] <= n3_reg[l][PROD_W-1];
            mag4_reg[l] <= n3_reg[l][PROD_W-1] ? MAG_W'(-n3_reg[l]) : MAG_W'(n3_reg[l]);
        end
    end

    // Stage 5: dividend with half-divisor bias for round to nearest
    always_ff @(posedge clk)
    begin
        side5_reg.bad <= bad4_reg;
        side5_reg.neg <= neg4_reg;
        den5_reg      <= {det4_reg, 1'b0};
        for (int l = 0; l < NUM_LANES; l++)
        begin
            num5_reg[l] <= NUM_W'({mag4_reg[l], {NUM_SHIFT{1'b0}}}) + NUM_W'(det4_reg);
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign num       = num5_reg;
    assign den       = den5_reg;
    assign side      = side5_reg;

endmodule

`default_nettype wire

// File: design/p1ts_div_pipe.sv
// ----------------------------------------------------------------------------
// p1ts_div_pipe
// Pipelined restoring divider, six lanes sharing one divisor. One range
// check stage, then one quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module p1ts_div_pipe
    import p1ts_pkg::*;
#(
    parameter int  COORD_WIDTH = P1TS_COORD_WIDTH,
    parameter int  ENTRY_WIDTH = P1TS_ENTRY_WIDTH,
    localparam int NUM_W       = num_width(COORD_WIDTH),
    localparam int DEN_W       = den_width(COORD_WIDTH)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [NUM_W-1:0]       num [NUM_LANES],
    input  logic [DEN_W-1:0]       den,
    input  p1ts_side_t             side_in,
    output logic                   out_valid,
    output logic [ENTRY_WIDTH-1:0] quo [NUM_LANES],
    output logic [NUM_LANES-1:0]   ovf,
    output p1ts_side_t             side_out
);

    localparam int REM_W = DEN_W + ENTRY_WIDTH;

    logic [ENTRY_WIDTH:0]     valid_reg;
    logic [REM_W-1:0]         rem_reg  [ENTRY_WIDTH][NUM_LANES];
    logic [ENTRY_WIDTH-1:0]   quo_reg  [1:ENTRY_WIDTH][NUM_LANES];
    logic [DEN_W-1:0]         den_reg  [ENTRY_WIDTH];
    logic [NUM_LANES-1:0]     ovf_reg  [ENTRY_WIDTH+1];
    p1ts_side_t               side_reg [ENTRY_WIDTH+1];

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ENTRY_WIDTH-1:0], in_valid};
        end
    end

    // Range check: a quotient of 2^ENTRY_WIDTH or more always saturates
    always_ff @(posedge clk)
    begin
        den_reg[0]  <= den;
        side_reg[0] <= side_in;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rem_reg[0][l] <= REM_W'(num[l]);
            ovf_reg[0][l] <= REM_W'(num[l]) >= (REM_W'(den) << ENTRY_WIDTH);
        end
    end

    // One quotient bit per stage
    for (genvar g = 1; g <= ENTRY_WIDTH; g++)
    begin : g_step
        logic [REM_W-1:0]     step_den;
        logic [NUM_LANES-1:0] ge;

        assign step_den = REM_W'(den_reg[g-1]) << (ENTRY_WIDTH - g);

        always_comb
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                ge[l] = rem_reg[g-1][l] >= step_den;
            end
        end

        always_ff @(posedge clk)
        begin
            ovf_reg[g]  <= ovf_reg[g-1];
            side_reg[g] <= side_reg[g-1];
        end

        if (g == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    quo_reg[g][l] <= ENTRY_WIDTH'(ge[l]);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    quo_reg[g][l] <= {quo_reg[g-1][l][ENTRY_WIDTH-2:0], ge[l]};
                end
            end
        end

        // Hold remainder and divisor only where a later stage reads them
        if (g < ENTRY_WIDTH)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                den_reg[g] <= den_reg[g-1];
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    rem_reg[g][l] <= ge[l] ? (rem_reg[g-1][l] - step_den) : rem_reg[g-1][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[ENTRY_WIDTH];
    assign quo       = quo_reg[ENTRY_WIDTH];
    assign ovf       = ovf_reg[ENTRY_WIDTH];
    assign side_out  = side_reg[ENTRY_WIDTH];

endmodule

`default_nettype wire

// File: design/p1_triangle_stiffness_core.sv
// ----------------------------------------------------------------------------
// p1_triangle_stiffness_core
// Stiffness matrix of a linear triangle for the Poisson operator.
//
// Usage: present the six corner coordinates (signed Q16.16) with start high.
// busy is always low, so a beat is taken on every edge where start is high;
// a new triangle may follow in every cycle. Each triangle gives one result
// beat: done is high for exactly one cycle with k00..k22 (signed Q24.16,
// rounded to nearest with ties away from zero, saturated) and bad_area.
// When the triangle has zero area or clockwise corners, bad_area is high
// and all entries are zero.
// Throughput is one triangle per cycle. Five front stages form edge terms,
// products, determinant and dividends; the pipelined divider then spends
// one range check stage plus one stage per entry bit; one stage saturates
// and drives the outputs. Reset clears all valid bits; beats in flight are
// dropped. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module p1_triangle_stiffness_core
    import p1ts_pkg::*;
#(
    parameter int COORD_WIDTH = P1TS_COORD_WIDTH,
    parameter int ENTRY_WIDTH = P1TS_ENTRY_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] node0_x,
    input  logic signed [COORD_WIDTH-1:0] node0_y,
    input  logic signed [COORD_WIDTH-1:0] node1_x,
    input  logic signed [COORD_WIDTH-1:0] node1_y,
    input  logic signed [COORD_WIDTH-1:0] node2_x,
    input  logic signed [COORD_WIDTH-1:0] node2_y,
    output logic                          done,
    output logic signed [ENTRY_WIDTH-1:0] k00,
    output logic signed [ENTRY_WIDTH-1:0] k01,
    output logic signed [ENTRY_WIDTH-1:0] k02,
    output logic signed [ENTRY_WIDTH-1:0] k10,
    output logic signed [ENTRY_WIDTH-1:0] k11,
    output logic signed [ENTRY_WIDTH-1:0] k12,
    output logic signed [ENTRY_WIDTH-1:0] k20,
    output logic signed [ENTRY_WIDTH-1:0] k21,
    output logic signed [ENTRY_WIDTH-1:0] k22,
    output logic                          bad_area
);

    localparam int NUM_W   = num_width(COORD_WIDTH);
    localparam int DEN_W   = den_width(COORD_WIDTH);
    localparam int LATENCY = ENTRY_WIDTH + 7;

    localparam logic [ENTRY_WIDTH-1:0] ENT_MIN = {1'b1, {(ENTRY_WIDTH-1){1'b0}}};
    localparam logic [ENTRY_WIDTH-1:0] ENT_MAX = ~ENT_MIN;

    logic                     front_valid;
    logic [NUM_W-1:0]         front_num [NUM_LANES];
    logic [DEN_W-1:0]         front_den;
    p1ts_side_t               front_side;

    logic                     div_valid;
    logic [ENTRY_WIDTH-1:0]   div_quo [NUM_LANES];
    logic [NUM_LANES-1:0]     div_ovf;
    p1ts_side_t               div_side;

    logic signed [ENTRY_WIDTH-1:0] ent_next [NUM_LANES];
    logic signed [ENTRY_WIDTH-1:0] ent_reg  [NUM_LANES];
    logic                          bad_reg;
    logic                          done_reg;

    // Every edge with start high takes a beat
    assign busy = 1'b0;

    p1ts_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .node0_x   (node0_x),
        .node0_y   (node0_y),
        .node1_x   (node1_x),
        .node1_y   (node1_y),
        .node2_x   (node2_x),
        .node2_y   (node2_y),
        .out_valid (front_valid),
        .num       (front_num),
        .den       (front_den),
        .side      (front_side)
    );

    p1ts_div_pipe #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .num       (front_num),
        .den       (front_den),
        .side_in   (front_side),
        .out_valid (div_valid),
        .quo       (div_quo),
        .ovf       (div_ovf),
        .side_out  (div_side)
    );

    // Saturate, apply sign, zero out entries of a bad triangle
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (div_side.bad)
            begin
                ent_next[l] = '0;
            end
            else if (div_side.neg[l])
            begin
                if (div_ovf[l] || (div_quo[l] > ENT_MIN))
                begin
                    ent_next[l] = ENT_MIN;
                end
                else
                begin
                    ent_next[l] = '0 - div_quo[l];
                end
            end
            else
            begin
                if (div_ovf[l] || div_quo[l][ENTRY_WIDTH-1])
                begin
                    ent_next[l] = ENT_MAX;
                end
                else
                begin
                    ent_next[l] = div_quo[l];
                end
            end
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        bad_reg <= div_side.bad;
    end

    // Output register: strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    // Mirror the symmetric entries
    assign done     = done_reg;
    assign bad_area = bad_reg;
    assign k00      = ent_reg[LANE_00];
    assign k01      = ent_reg[LANE_01];
    assign k02      = ent_reg[LANE_02];
    assign k10      = ent_reg[LANE_01];
    assign k11      = ent_reg[LANE_11];
    assign k12      = ent_reg[LANE_12];
    assign k20      = ent_reg[LANE_02];
    assign k21      = ent_reg[LANE_12];
    assign k22      = ent_reg[LANE_22];

    // Bad triangle gives an all-zero matrix
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_area |-> (k00 == '0) && (k01 == '0) && (k02 == '0) &&
                             (k11 == '0) && (k12 == '0) && (k22 == '0))
        else $error("bad triangle with nonzero entries");

    // Diagonal entries are sums of squares over a positive area
    a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && !bad_area |-> !k00[ENTRY_WIDTH-1] && !k11[ENTRY_WIDTH-1] &&
                              !k22[ENTRY_WIDTH-1])
        else $error("negative diagonal entry");

    // Every result traces back to a beat taken a fixed time earlier
    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching input beat");

    // Every beat taken yields a result after the fixed latency
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("input beat lost in pipeline");

endmodule

`default_nettype wire

// File: bench/p1_triangle_stiffness_core_tb.sv
// ----------------------------------------------------------------------------
// p1_triangle_stiffness_core_tb
// Self-checking bench for the P1 triangle stiffness core. A short table of
// hand-picked triangles (unit, translated, degenerate, clockwise, saturating,
// full-scale corners, rounding ties) comes first, then a long stream of random
// triangles of several shapes. Each taken beat is scored against an exact
// wide-integer model of the matrix, or against the typed-in matrix for the
// rows that carry one, and each done beat is matched to the oldest entry.
// ----------------------------------------------------------------------------
module p1_triangle_stiffness_core_tb
    import p1ts_pkg::*;
();

    localparam int CW           = P1TS_COORD_WIDTH;
    localparam int EW           = P1TS_ENTRY_WIDTH;
    localparam int RANDOM_BEATS = 1730;
    localparam int SETTLE       = EW + 16;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] entry_t;

    typedef struct packed {
        coord_t x0, y0, x1, y1, x2, y2;
    } corners_t;

    typedef struct packed {
        logic                bad;
        logic [0:8][EW-1:0]  k;     // row-major, k[0] is k00
    } stiffness_t;

    typedef struct packed {
        corners_t   at;
        logic       typed;          // matrix below is checked as written
        stiffness_t want;
    } tri_row_t;

    typedef enum {
        SHAPE_WELL,
        SHAPE_THIN,
        SHAPE_FLAT,
        SHAPE_CW,
        SHAPE_WILD
    } shape_t;

    localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t ONE  = 65536;
    localparam coord_t TWO  = 131072;
    localparam coord_t PAT5 = 32'sh5555_5555;
    localparam coord_t PATA = 32'shAAAA_AAAA;

    localparam entry_t ENTRY_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam entry_t ENTRY_MIN = {1'b1, {(EW-1){1'b0}}};
    localparam logic [127:0] ENTRY_LIM = 128'd1 << (EW - 1);

    localparam stiffness_t NO_AREA = '{bad: 1'b1, k: '0};
    // Unit right triangle: one half of [2 -1 -1; -1 1 0; -1 0 1]
    localparam stiffness_t UNIT_RIGHT = '{bad: 1'b0,
        k: '{65536, -32768, -32768, -32768, 32768, 0, -32768, 0, 32768}};
    // Sliver with det = 1 raw unit: all but k22 pinned at a rail
    localparam stiffness_t SLIVER_SAT = '{bad: 1'b0,
        k: '{ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN,
             ENTRY_MAX, ENTRY_MIN, 32768}};

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    coord_t     node0_x = '0;
    coord_t     node0_y = '0;
    coord_t     node1_x = '0;
    coord_t     node1_y = '0;
    coord_t     node2_x = '0;
    coord_t     node2_y = '0;
    logic       done;
    entry_t     k00, k01, k02, k10, k11, k12, k20, k21, k22;
    logic       bad_area;

    // Side data that travels with the beat on the input side
    logic       row_typed = 1'b0;
    stiffness_t row_want  = '0;

    stiffness_t stiffness_q [$];
    stiffness_t got;
    stiffness_t want_now;
    int         errors      = 0;
    int         checked     = 0;
    int         typed_seen  = 0;
    int         bad_seen    = 0;
    int         sat_seen    = 0;

    p1_triangle_stiffness_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .node0_x  (node0_x),
        .node0_y  (node0_y),
        .node1_x  (node1_x),
        .node1_y  (node1_y),
        .node2_x  (node2_x),
        .node2_y  (node2_y),
        .done     (done),
        .k00      (k00),
        .k01      (k01),
        .k02      (k02),
        .k10      (k10),
        .k11      (k11),
        .k12      (k12),
        .k20      (k20),
        .k21      (k21),
        .k22      (k22),
        .bad_area (bad_area)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact stiffness matrix: wide integers, round half away from zero, clamp
    function automatic stiffness_t predict_stiffness(input corners_t t);
        logic signed [127:0] px [3];
        logic signed [127:0] py [3];
        logic signed [127:0] eb [3];
        logic signed [127:0] ec [3];
        logic signed [127:0] area2;
        logic signed [127:0] dot;
        logic [127:0]        mag;
        logic [127:0]        quo;
        stiffness_t          r;
        int                  i;
        int                  j;
        px[0] = $signed(t.x0);
        py[0] = $signed(t.y0);
        px[1] = $signed(t.x1);
        py[1] = $signed(t.y1);
        px[2] = $signed(t.x2);
        py[2] = $signed(t.y2);
        eb[0] = py[1] - py[2];
        eb[1] = py[2] - py[0];
        eb[2] = py[0] - py[1];
        ec[0] = px[2] - px[1];
        ec[1] = px[0] - px[2];
        ec[2] = px[1] - px[0];
        area2 = (px[1] - px[0]) * (py[2] - py[0]) - (px[2] - px[0]) * (py[1] - py[0]);
        r     = '0;
        r.bad = (area2 <= 0);
        if (!r.bad)
        begin
            for (i = 0; i < 3; i++)
            begin
                for (j = 0; j < 3; j++)
                begin
                    dot = eb[i] * eb[j] + ec[i] * ec[j];
                    mag = (dot < 0) ? -dot : dot;
                    quo = ((mag << NUM_SHIFT) + area2) / (area2 << 1);
                    if (dot < 0)
                        r.k[3*i+j] = EW'((quo > ENTRY_LIM) ? -ENTRY_LIM : -quo);
                    else
                        r.k[3*i+j] = EW'((quo > ENTRY_LIM - 1) ? ENTRY_LIM - 1 : quo);
                end
            end
        end
        return r;
    endfunction

    // Signed random value in [-2^bits, 2^bits - 1]
    function automatic coord_t span(input int bits);
        return $signed($urandom) >>> (31 - bits);
    endfunction

    function automatic corners_t random_corners(input shape_t shape);
        corners_t t;
        longint   area;
        int       scale;
        coord_t   hold;
        scale = $urandom_range(1, 26);
        t.x0  = span(26);
        t.y0  = span(26);
        case (shape)
            SHAPE_THIN:
            begin
                // corners 1 and 2 nearly coincide: det tiny against long edges
                t.x1 = t.x0 + span(26);
                t.y1 = t.y0 + span(26);
                t.x2 = t.x1 + span($urandom_range(0, 3));
                t.y2 = t.y1 + span($urandom_range(0, 3));
            end
            SHAPE_FLAT:
            begin
                t.x1 = t.x0 + span(scale);
                t.y1 = t.y0 + span(scale);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        t.x2 = t.x1 + t.x1 - t.x0;
                        t.y2 = t.y1 + t.y1 - t.y0;
                    end
                    1:
                    begin
                        t.x2 = t.x0;
                        t.y2 = t.y0;
                    end
                    default:
                    begin
                        t.x2 = t.x1;
                        t.y2 = t.y1;
                    end
                endcase
            end
            SHAPE_WILD:
            begin
                t.x0 = $urandom;
                t.y0 = $urandom;
                t.x1 = $urandom;
                t.y1 = $urandom;
                t.x2 = $urandom;
                t.y2 = $urandom;
            end
            default:
            begin
                t.x1 = t.x0 + span(scale);
                t.y1 = t.y0 + span(scale);
                t.x2 = t.x0 + span(scale);
                t.y2 = t.y0 + span(scale);
            end
        endcase
        // Fix winding: counter-clockwise unless a clockwise one is wanted
        if (shape != SHAPE_WILD && shape != SHAPE_FLAT)
        begin
            area = (longint'(t.x1) - t.x0) * (longint'(t.y2) - t.y0)
                 - (longint'(t.x2) - t.x0) * (longint'(t.y1) - t.y0);
            if ((area < 0) != (shape == SHAPE_CW))
            begin
                hold = t.x1;
                t.x1 = t.x2;
                t.x2 = hold;
                hold = t.y1;
                t.y1 = t.y2;
                t.y2 = hold;
            end
        end
        return t;
    endfunction

    // Idle first when gap is nonzero, then hold the beat until it is taken
    task automatic send_triangle(input corners_t t, input logic typed,
                                 input stiffness_t want, input int gap);
        bit took;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        node0_x   <= t.x0;
        node0_y   <= t.y0;
        node1_x   <= t.x1;
        node1_y   <= t.y1;
        node2_x   <= t.x2;
        node2_y   <= t.y2;
        row_typed <= typed;
        row_want  <= want;
        do
        begin
            took = !busy;
            @(negedge clk);
        end while (!took);
    endtask

    // Drop start and wait until every expected matrix has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (stiffness_q.size() != 0);
    endtask

    // Score taken beats and returned matrices at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                stiffness_q.push_back(row_typed ? row_want :
                    predict_stiffness({node0_x, node0_y, node1_x, node1_y,
                                       node2_x, node2_y}));
                typed_seen += row_typed;
            end
            if (done)
            begin
                got = {bad_area, k00, k01, k02, k10, k11, k12, k20, k21, k22};
                if (stiffness_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with no triangle pending", $time);
                end
                else
                begin
                    want_now = stiffness_q.pop_front();
                    checked++;
                    bad_seen += got.bad;
                    if (got.bad !== want_now.bad)
                    begin
                        errors++;
                        $display("%0t: bad_area expected %0b, got %0b",
                                 $time, want_now.bad, got.bad);
                    end
                    for (int e = 0; e < 9; e++)
                    begin
                        if (got.k[e] == ENTRY_MAX || got.k[e] == ENTRY_MIN)
                            sat_seen++;
                        if (got.k[e] !== want_now.k[e])
                        begin
                            errors++;
                            $display("%0t: k%0d%0d expected %0d, got %0d", $time,
                                     e / 3, e % 3, $signed(entry_t'(want_now.k[e])),
                                     $signed(entry_t'(got.k[e])));
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        tri_row_t directed_rows [$];
        shape_t   shape;
        int       pick;
        bit       burst;
        directed_rows = '{
            '{'{0, 0, 0, 0, 0, 0}, 1'b1, NO_AREA},
            '{'{0, 0, ONE, 0, 0, ONE}, 1'b1, UNIT_RIGHT},
            '{'{0, 0, 0, ONE, ONE, 0}, 1'b1, NO_AREA},
            '{'{0, 0, ONE, ONE, TWO, TWO}, 1'b1, NO_AREA},
            '{'{ONE, ONE, ONE, ONE, -5, 7}, 1'b1, NO_AREA},
            '{'{0, 0, 1, 0, CMAX, 1}, 1'b1, SLIVER_SAT},
            '{'{65536000, -65536000, 65601536, -65536000, 65536000, -65470464},
              1'b1, UNIT_RIGHT},
            '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN}, 1'b1, NO_AREA},
            '{'{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX}, 1'b0, '0},
            '{'{CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, '0},
            '{'{CMIN, 0, CMAX, 0, 0, CMAX}, 1'b0, '0},
            '{'{0, 0, CMAX, 0, 0, 1}, 1'b0, '0},
            '{'{0, 0, 1, 0, 0, 1}, 1'b0, '0},
            '{'{0, 0, TWO, 0, 0, 1}, 1'b0, '0},
            '{'{0, 0, TWO, 0, 1, 1}, 1'b0, '0},
            '{'{-229376, -147456, -65536, -131072, -131072, 311296}, 1'b0, '0},
            '{'{PATA, PATA, PAT5, PATA, PATA, PAT5}, 1'b0, '0},
            '{'{PAT5, PAT5, PATA, PAT5, PAT5, PATA}, 1'b0, '0}
        };

        // Hold reset, then release away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (directed_rows[r])
            send_triangle(directed_rows[r].at, directed_rows[r].typed,
                          directed_rows[r].want, $urandom_range(0, 6));

        // Random triangles in bursts and gapped stretches
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 64 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_BEATS / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 45)
                shape = SHAPE_WELL;
            else if (pick < 65)
                shape = SHAPE_THIN;
            else if (pick < 75)
                shape = SHAPE_FLAT;
            else if (pick < 85)
                shape = SHAPE_CW;
            else
                shape = SHAPE_WILD;
            send_triangle(random_corners(shape), 1'b0, '0,
                          burst ? 0 : $urandom_range(0, 6));
        end

        // Let the pipe empty, then watch for stray result beats
        drain_results();
        repeat (SETTLE) @(negedge clk);

        $display("Covered %0d triangles (%0d with typed matrices), %0d with bad area,",
                 checked, typed_seen, bad_seen);
        $display("%0d saturated entries seen, %0d mismatches.", sat_seen, errors);
        if (errors == 0)
            $display("p1_triangle_stiffness_core_tb: PASS");
        else
            $display("p1_triangle_stiffness_core_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timed out with %0d results still pending.", stiffness_q.size());
        $display("p1_triangle_stiffness_core_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/p1ts_pkg.sv
design/p1ts_front.sv
design/p1ts_div_pipe.sv
design/p1_triangle_stiffness_core.sv
bench/p1_triangle_stiffness_core_tb.sv
